// ----- rtl/core/bsed_pkg.sv -----
package bsed_pkg;

    localparam logic [7:0] CHAR_BSL  = 8'h5C;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX0 = 3'd2,
        PH_HEX1 = 3'd3,
        PH_OCT  = 3'd4,
        PH_HOLD = 3'd5
    } phase_t;

    // results of one accepted byte, handed from parser to queue
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] data0;
        logic       last0;
        logic [7:0] data1;
        logic       last1;
    } result_t;

    typedef struct packed {
        logic [8:0] entry;
    } qslot_t;

    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
    endfunction

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ----- rtl/core/bsed_if.sv -----
interface bsed_in_if;
    import bsed_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bsed_out_if;
    import bsed_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/core/bsed_parser.sv -----
module bsed_parser
    import bsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] pend_reg, pend_next;
    logic [1:0] digits_reg, digits_next;

    // plain byte handling, used on its own or after a flushed value
    phase_t     pl_phase;
    logic       pl_emit;
    logic [7:0] pl_data;
    logic       pl_last;

    always_comb
    begin
        pl_phase = PH_IDLE;
        pl_emit  = 1'b1;
        pl_data  = in_byte;
        pl_last  = in_last;
        if (in_byte == CHAR_BSL && !in_last)
        begin
            pl_phase = PH_ESC;
            pl_emit  = 1'b0;
        end
    end

    always_comb
    begin
        logic [4:0] hx;
        logic [7:0] oval;
        logic [1:0] dnext;
        hx    = hex_decode(in_byte);
        oval  = {pend_reg[4:0], in_byte[2:0]};
        dnext = (digits_reg != 2'd0) ? digits_reg - 2'd1 : 2'd0;

        phase_next  = phase_reg;
        pend_next   = pend_reg;
        digits_next = digits_reg;
        res         = '0;

        unique case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_IDLE;
                if (in_byte == CHAR_X)
                begin
                    if (in_last)
                        res = '{count: 2'd2, data0: CHAR_BSL, last0: 1'b0,
                                data1: CHAR_X, last1: 1'b1};
                    else
                        phase_next = PH_HEX0;
                end
                else if (is_octal(in_byte))
                begin
                    pend_next   = {5'd0, in_byte[2:0]};
                    digits_next = (in_byte == CHAR_ZERO) ? 2'd3 : 2'd2;
                    if (in_last)
                        res = '{count: 2'd1, data0: {5'd0, in_byte[2:0]}, last0: 1'b1,
                                data1: 8'd0, last1: 1'b0};
                    else
                        phase_next = PH_OCT;
                end
                else if (in_byte == CHAR_BSL)
                    res = '{count: 2'd1, data0: CHAR_BSL, last0: in_last,
                            data1: 8'd0, last1: 1'b0};
                else
                    res = '{count: 2'd2, data0: CHAR_BSL, last0: 1'b0,
                            data1: in_byte, last1: in_last};
            end
            PH_HEX0:
            begin
                if (hx[4])
                begin
                    pend_next = {4'd0, hx[3:0]};
                    if (in_last)
                    begin
                        res = '{count: 2'd1, data0: {4'd0, hx[3:0]}, last0: 1'b1,
                                data1: 8'd0, last1: 1'b0};
                        phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_HEX1;
                end
                else
                begin
                    // backslash x with no digit: give both back literally
                    res = '{count: 2'd2, data0: CHAR_BSL, last0: 1'b0,
                            data1: CHAR_X, last1: in_last};
                    if (in_byte == CHAR_BSL && !in_last)
                        phase_next = PH_ESC;
                    else if (in_last)
                        phase_next = PH_IDLE;
                    else
                    begin
                        pend_next  = in_byte;
                        phase_next = PH_HOLD;
                    end
                end
            end
            PH_HEX1:
            begin
                if (hx[4])
                begin
                    res = '{count: 2'd1, data0: {pend_reg[3:0], hx[3:0]}, last0: in_last,
                            data1: 8'd0, last1: 1'b0};
                    phase_next = PH_IDLE;
                end
                else
                begin
                    res = '{count: {1'b0, 1'b1} + {1'b0, pl_emit}, data0: pend_reg,
                            last0: 1'b0, data1: pl_data, last1: pl_last};
                    phase_next = pl_phase;
                end
            end
            PH_OCT:
            begin
                if (is_octal(in_byte))
                begin
                    pend_next   = oval;
                    digits_next = dnext;
                    if (dnext == 2'd0 || in_last)
                    begin
                        res = '{count: 2'd1, data0: oval, last0: in_last,
                                data1: 8'd0, last1: 1'b0};
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    res = '{count: {1'b0, 1'b1} + {1'b0, pl_emit}, data0: pend_reg,
                            last0: 1'b0, data1: pl_data, last1: pl_last};
                    phase_next = pl_phase;
                end
            end
            PH_HOLD:
            begin
                res = '{count: {1'b0, 1'b1} + {1'b0, pl_emit}, data0: pend_reg,
                        last0: 1'b0, data1: pl_data, last1: pl_last};
                phase_next = pl_phase;
            end
            default:
            begin
                res = '{count: {1'b0, pl_emit}, data0: pl_data, last0: pl_last,
                        data1: 8'd0, last1: 1'b0};
                phase_next = pl_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pend_reg   <= '0;
            digits_reg <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            digits_reg <= digits_next;
        end
    end

endmodule

// ----- rtl/core/bsed_outq.sv -----
module bsed_outq
    import bsed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t res,
    output logic    room,
    bsed_out_if.source dst
);

    qslot_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;
    logic [1:0]        n_push;
    logic [QPTR_W-1:0] wr_second;

    assign pop       = dst.valid && dst.ready;
    assign n_push    = push ? res.count : 2'd0;
    assign wr_second = qptr_inc(wr_reg);

    // room for two results regardless of the far side
    assign room = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    assign dst.valid    = (cnt_reg != '0);
    assign dst.out_byte = slot_reg[rd_reg].entry[8:1];
    assign dst.out_last = slot_reg[rd_reg].entry[0];

    always_comb
    begin
        wr_next  = wr_reg;
        if (n_push == 2'd1)
            wr_next = wr_second;
        else if (n_push == 2'd2)
            wr_next = qptr_inc(wr_second);
        rd_next  = pop ? qptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            slot_reg[wr_reg].entry <= {res.data0, res.last0};
        if (n_push == 2'd2)
            slot_reg[wr_second].entry <= {res.data1, res.last1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/backslash_escape_decoder_top.sv -----
// channel   | role   | payload            | transfer when
// ----------+--------+--------------------+------------------------
// text      | sink   | in_byte, in_last   | text.valid && text.ready
// decoded   | source | out_byte, out_last | decoded.valid && decoded.ready
//
// one byte is taken per cycle; each transfer is parsed in the same cycle and its
// zero, one or two results land in a three-entry result queue, first one offered next cycle
// text.ready looks only at queue room for two results, never directly at decoded.ready;
// a stalled far side fills the queue and then holds off input until results drain
// a byte giving two results leaves an extra result to drain, which briefly holds
// off input when the far side drains one result per cycle
// rst_n clears the parse phase and empties the queue; no other setup is needed
module backslash_escape_decoder_top
    import bsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsed_in_if.sink    text,
    bsed_out_if.source decoded
);

    logic    take;
    logic    room;
    result_t res;

    // input is accepted whenever the queue can hold a worst case result pair
    assign text.ready = room;
    assign take       = text.valid && room;

    // escape parser: phase, pending value and digit count
    bsed_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (text.in_byte),
        .in_last (text.in_last),
        .res     (res)
    );

    // result queue, registered output
    bsed_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .res   (res),
        .room  (room),
        .dst   (decoded)
    );

endmodule
